@@ hdl/wmf_pkg.sv @@
`default_nettype none

package wmf_pkg;

    // Default bin value width and bin count width.
    localparam int VALUE_BITS_DEF = 8;
    localparam int COUNT_BITS_DEF = 8;

    // Widths of the fixed stream fields.
    localparam int SAMPLE_W = 8;
    localparam int MODE_W   = 8;
    localparam int WIN_W    = 8;

    // A histogram row never has more than this many address bits, so the
    // per-row valid flags stay a small register file.
    localparam int ROW_BITS_MAX = 8;

    // Window length after reset.
    localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd16;

    // Control for the update stage of both histogram channels.
    typedef struct packed {
        logic advance;  // the item in the update stage moves on this cycle
        logic last;     // that item closes the window
    } wmf_step_t;

endpackage

`default_nettype wire

@@ hdl/wmf_hist_chan.sv @@
`default_nettype none

module wmf_hist_chan #(
    parameter int VALUE_BITS = wmf_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = wmf_pkg::COUNT_BITS_DEF
) (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        rd_en,
    input  wire       [VALUE_BITS-1:0] rd_value,
    input  wire wmf_pkg::wmf_step_t    step,
    output logic      [VALUE_BITS-1:0] mode
);

    localparam int ROW_BITS  = (VALUE_BITS > wmf_pkg::ROW_BITS_MAX) ?
                               wmf_pkg::ROW_BITS_MAX : VALUE_BITS;
    localparam int LANE_BITS = VALUE_BITS - ROW_BITS;
    localparam int LANES     = 1 << LANE_BITS;
    localparam int ROWS      = 1 << ROW_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef logic [LANES-1:0][COUNT_BITS-1:0] row_word_t;

    // Histogram storage: one row holds the counts of LANES adjacent bins.
    row_word_t mem [ROWS];

    row_word_t             rdata_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;
    logic [ROWS-1:0]       valid_reg;
    logic                  fwd_valid_reg;
    logic [ROW_BITS-1:0]   fwd_row_reg;
    row_word_t             fwd_word_reg;
    logic [VALUE_BITS-1:0] best_val_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;

    logic [ROW_BITS-1:0]   rd_row;
    logic [ROW_BITS-1:0]   s1_row;
    logic                  fwd_hit;
    row_word_t             base_word;
    row_word_t             new_word;
    logic [COUNT_BITS-1:0] old_cnt;
    logic [COUNT_BITS-1:0] new_cnt;
    logic                  better;
    logic [VALUE_BITS-1:0] best_val_next;
    logic [COUNT_BITS-1:0] best_cnt_next;

    assign rd_row = rd_value[VALUE_BITS-1:LANE_BITS];
    assign s1_row = s1_value_reg[VALUE_BITS-1:LANE_BITS];

    // The row read at acceptance misses a write made on the same edge; the
    // last written row is kept aside and replaces the read data on a match.
    // A row whose valid flag is clear belongs to an earlier window.
    assign fwd_hit = fwd_valid_reg && (fwd_row_reg == s1_row);

    always_comb begin
        if (!valid_reg[s1_row]) begin
            base_word = '0;
        end else if (fwd_hit) begin
            base_word = fwd_word_reg;
        end else begin
            base_word = rdata_reg;
        end
    end

    // Pick the bin out of its row and put the new count back in.
    generate
        if (LANE_BITS > 0) begin : g_lanes
            logic [LANE_BITS-1:0] s1_lane;
            assign s1_lane = s1_value_reg[LANE_BITS-1:0];
            assign old_cnt = base_word[s1_lane];
            always_comb begin
                new_word          = base_word;
                new_word[s1_lane] = new_cnt;
            end
        end else begin : g_single
            assign old_cnt = base_word[0];
            always_comb begin
                new_word    = base_word;
                new_word[0] = new_cnt;
            end
        end
    endgenerate

    // Saturating bin increment.
    assign new_cnt = (old_cnt == COUNT_MAX) ? old_cnt : old_cnt + 1'b1;

    // Running mode: a higher count wins, a tie goes to the larger value.
    assign better = (new_cnt > best_cnt_reg) ||
                    ((new_cnt == best_cnt_reg) && (s1_value_reg > best_val_reg));
    assign best_val_next = better ? s1_value_reg : best_val_reg;
    assign best_cnt_next = better ? new_cnt : best_cnt_reg;
    assign mode          = best_val_next;

    // Row memory with registered read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg    <= mem[rd_row];
            s1_value_reg <= rd_value;
        end
        if (step.advance && !step.last) begin
            mem[s1_row] <= new_word;
        end
    end

    // Valid flags, bypass row and best tracker; all cleared at window end.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            fwd_row_reg   <= '0;
            fwd_word_reg  <= '0;
            best_val_reg  <= '0;
            best_cnt_reg  <= '0;
        end else if (step.advance) begin
            if (step.last) begin
                valid_reg     <= '0;
                fwd_valid_reg <= 1'b0;
                best_val_reg  <= '0;
                best_cnt_reg  <= '0;
            end else begin
                valid_reg[s1_row] <= 1'b1;
                fwd_valid_reg     <= 1'b1;
                fwd_row_reg       <= s1_row;
                fwd_word_reg      <= new_word;
                best_val_reg      <= best_val_next;
                best_cnt_reg      <= best_cnt_next;
            end
        end
    end

`ifndef ASSERT_OFF
    // A window end leaves the tracker empty.
    a_clear_best : assert property (@(posedge aclk) disable iff (!aresetn)
        (step.advance && step.last) |=> (best_cnt_reg == '0 && valid_reg == '0))
        else $error("tracker not cleared at window end");

    // The best count only ever grows inside a window.
    a_best_grows : assert property (@(posedge aclk) disable iff (!aresetn)
        (step.advance && !step.last) |=> (best_cnt_reg >= $past(best_cnt_reg)))
        else $error("best count decreased inside a window");

    // After a counted update the bypass row is the row just written.
    a_fwd_row : assert property (@(posedge aclk) disable iff (!aresetn)
        (step.advance && !step.last) |=> (fwd_valid_reg && fwd_row_reg == $past(s1_row)))
        else $error("bypass row does not follow the last write");
`endif

endmodule

`default_nettype wire

@@ hdl/windowed_mode_filter_pair_core.sv @@
`default_nettype none

// Windowed mode filter for a pair of sensor channels (water level, flow).
// Slave stream s_*: one transfer carries one level sample and one flow sample.
// Master stream m_*: one transfer per window, carrying the mode of each
// channel over the window (most frequent value, a tie goes to the larger).
// cfg_*: writes the window length in samples (0 means 256); ready is always
// high, and it should only be written while the block is idle.
// A sample that closes a window is registered in the update stage; its
// result is then loaded into the output register that drives m_tvalid.
// Throughput: one sample per cycle, except while a window end is stalled.
// Each channel reads one row at acceptance and writes one row in the update
// stage, with a bypass of the last written row, so no sample waits on a row.
// Histograms are cleared at the window end through per-row valid flags.
// Reset: synchronous, active low. It empties the pipeline, clears the
// histograms, the sample count and the trackers, and sets the window to 16.
// Stall: a result waiting in the output register does not block samples;
// only a second window end that reaches a full output holds s_tready low.
module windowed_mode_filter_pair_core #(
    parameter int VALUE_BITS = wmf_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = wmf_pkg::COUNT_BITS_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // level_sample [7:0], flow_sample [15:8]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [15:0] m_tdata,   // level_mode [7:0], flow_mode [15:8]
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [7:0]  cfg_data   // window_size
);

    localparam int SW = wmf_pkg::SAMPLE_W;
    localparam int MW = wmf_pkg::MODE_W;
    localparam int WW = wmf_pkg::WIN_W;

    logic [WW-1:0]       window_size_reg;
    logic [WW-1:0]       count_reg;
    logic [WW-1:0]       count_inc;
    logic                s1_valid_reg;
    logic                s1_last_reg;
    logic                out_valid_reg;
    logic [2*MW-1:0]     out_data_reg;

    logic                in_accept;
    logic                in_last;
    logic                s1_advance;
    logic                out_load;
    wmf_pkg::wmf_step_t  step;
    logic [VALUE_BITS-1:0] level_value;
    logic [VALUE_BITS-1:0] flow_value;
    logic [VALUE_BITS-1:0] level_mode;
    logic [VALUE_BITS-1:0] flow_mode;

    assign cfg_ready = 1'b1;

    // The update stage holds only when it closes a window and the output
    // register still has an untaken result.
    assign s1_advance = s1_valid_reg && !(s1_last_reg && out_valid_reg && !m_tready);
    assign s_tready   = !s1_valid_reg || s1_advance;
    assign in_accept  = s_tvalid && s_tready;
    assign out_load   = s1_advance && s1_last_reg;

    assign step.advance = s1_advance;
    assign step.last    = s1_last_reg;

    // Sample count wraps at 256, so a window length of zero spans 256 samples.
    assign count_inc = count_reg + 1'b1;
    assign in_last   = (count_inc == window_size_reg);

    assign level_value = VALUE_BITS'(s_tdata[SW-1:0]);
    assign flow_value  = VALUE_BITS'(s_tdata[2*SW-1:SW]);

    wmf_hist_chan #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_level (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (in_accept),
        .rd_value (level_value),
        .step     (step),
        .mode     (level_mode)
    );

    wmf_hist_chan #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_flow (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .rd_en    (in_accept),
        .rd_value (flow_value),
        .step     (step),
        .mode     (flow_mode)
    );

    // Window register, sample counter and update stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= wmf_pkg::WINDOW_RESET;
            count_reg       <= '0;
            s1_valid_reg    <= 1'b0;
            s1_last_reg     <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                window_size_reg <= cfg_data;
            end
            if (in_accept) begin
                count_reg    <= in_last ? '0 : count_inc;
                s1_valid_reg <= 1'b1;
                s1_last_reg  <= in_last;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
                s1_last_reg  <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= {MW'(flow_mode), MW'(level_mode)};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // Input is held back only by a window end waiting on a full output.
    a_ready_cause : assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (s1_valid_reg && s1_last_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked window end");

    // A new result never overwrites one that has not been taken.
    a_no_overwrite : assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_tready))
        else $error("result register overwritten");

    // A sample that closes the window restarts the count.
    a_count_restart : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && in_last) |=> (count_reg == '0 && s1_last_reg))
        else $error("sample count not restarted at window end");

    // A blocked window end stays in the update stage.
    a_hold_last : assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_last_reg && !s1_advance) |=> (s1_valid_reg && s1_last_reg))
        else $error("blocked window end was lost");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb_windowed_mode_filter_pair_core.sv @@
`default_nettype none

module tb_windowed_mode_filter_pair_core;

    localparam int SAMPLE_W       = wmf_pkg::SAMPLE_W;
    localparam int MODE_W         = wmf_pkg::MODE_W;
    localparam int WIN_W          = wmf_pkg::WIN_W;
    localparam int VALUE_BITS_DEF = wmf_pkg::VALUE_BITS_DEF;
    localparam int COUNT_BITS_DEF = wmf_pkg::COUNT_BITS_DEF;

    localparam int NUM_BINS       = 1 << VALUE_BITS_DEF;
    localparam int COUNT_MAX      = (1 << COUNT_BITS_DEF) - 1;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 4;

    typedef struct packed {
        logic [MODE_W-1:0] level_mode;
        logic [MODE_W-1:0] flow_mode;
    } mode_pair_t;

    typedef enum int {
        CH_LEVEL = 0,
        CH_FLOW  = 1
    } channel_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // level_sample [7:0], flow_sample [15:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // level_mode [7:0], flow_mode [15:8]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;  // window_size

    // Shadow state of the filter.
    logic [COUNT_BITS_DEF-1:0] hist_bins [2][NUM_BINS];
    logic [SAMPLE_W-1:0]       lead_value [2];
    logic [COUNT_BITS_DEF-1:0] lead_count [2];
    logic [WIN_W-1:0]          window_len;
    logic [WIN_W-1:0]          fill_count;

    mode_pair_t expected_modes [$];

    int errors;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    // Per-window pools of likely values, so that modes and ties matter.
    logic [SAMPLE_W-1:0] level_pool [4];
    logic [SAMPLE_W-1:0] flow_pool [4];

    windowed_mode_filter_pair_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Clear both histograms, both trackers and the sample count.
    task automatic clear_histograms();
        for (int c = 0; c < 2; c++) begin
            for (int b = 0; b < NUM_BINS; b++) begin
                hist_bins[c][b] = '0;
            end
            lead_value[c] = '0;
            lead_count[c] = '0;
        end
        fill_count = '0;
    endtask

    // Count one sample into a channel and move its running leader.
    task automatic count_sample(input channel_t ch, input logic [SAMPLE_W-1:0] value);
        logic [COUNT_BITS_DEF-1:0] n;
        n = hist_bins[ch][value];
        if (n != COUNT_MAX[COUNT_BITS_DEF-1:0]) begin
            n = n + 1'b1;
        end
        hist_bins[ch][value] = n;
        if (n > lead_count[ch] || (n == lead_count[ch] && value > lead_value[ch])) begin
            lead_count[ch] = n;
            lead_value[ch] = value;
        end
    endtask

    // Advance the shadow filter by one accepted sample pair.
    task automatic predict_modes(input logic [SAMPLE_W-1:0] level,
                                 input logic [SAMPLE_W-1:0] flow);
        mode_pair_t m;
        fill_count = fill_count + 1'b1;
        count_sample(CH_LEVEL, level);
        count_sample(CH_FLOW, flow);
        if (fill_count == window_len) begin
            m.level_mode = lead_value[CH_LEVEL];
            m.flow_mode  = lead_value[CH_FLOW];
            expected_modes.push_back(m);
            clear_histograms();
        end
    endtask

    // Offer one sample pair, with random gaps, until it is transferred.
    task automatic send_pair(input logic [SAMPLE_W-1:0] level,
                             input logic [SAMPLE_W-1:0] flow);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {flow, level};
        do @(posedge aclk); while (!s_tready);
        predict_modes(level, flow);
    endtask

    // Stop offering samples and wait until every expected result is out.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_modes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the window length while the block is idle.
    task automatic set_window(input logic [WIN_W-1:0] len);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do @(posedge aclk); while (!cfg_ready);
        window_len = len;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic refill_pools();
        for (int i = 0; i < 4; i++) begin
            level_pool[i] = SAMPLE_W'($urandom_range(0, 255));
            flow_pool[i]  = SAMPLE_W'($urandom_range(0, 255));
        end
    endtask

    // Mostly values from the small pools, some anywhere in the range.
    task automatic send_random_pair();
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] flow;
        int pool_n;
        pool_n = $urandom_range(2, 4);
        level = ($urandom_range(0, 99) < 80) ? level_pool[$urandom_range(0, pool_n - 1)]
                                             : SAMPLE_W'($urandom_range(0, 255));
        flow  = ($urandom_range(0, 99) < 80) ? flow_pool[$urandom_range(0, pool_n - 1)]
                                             : SAMPLE_W'($urandom_range(0, 255));
        send_pair(level, flow);
    endtask

    // Window of 16 after reset: extremes, alternating bits and ties in count.
    task automatic test_default_window();
        logic [SAMPLE_W-1:0] lvl [16];
        logic [SAMPLE_W-1:0] flw [16];
        lvl = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h03, 8'h03, 8'h09, 8'h09,
                8'h09, 8'h03, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
        flw = '{8'h80, 8'h01, 8'hFE, 8'h7F, 8'h20, 8'h20, 8'h20, 8'h10,
                8'h10, 8'h10, 8'h10, 8'h20, 8'h7F, 8'hFE, 8'h01, 8'h80};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 16; i++) begin
            send_pair(lvl[i], flw[i]);
        end
    endtask

    // Smallest window: every sample is its own mode.
    task automatic test_window_one();
        set_window(8'd1);
        send_pair(8'h00, 8'hFF);
        send_pair(8'hFF, 8'h00);
        send_pair(8'h55, 8'hAA);
        send_pair(8'hAA, 8'h55);
    endtask

    // Largest nonzero window length.
    task automatic test_window_max();
        set_window(8'd255);
        refill_pools();
        repeat (255) send_random_pair();
    endtask

    // Window of zero spans 256 samples; one value in all of them saturates its bin.
    task automatic test_window_zero_saturation();
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] flow;
        set_window(8'd0);
        level = SAMPLE_W'($urandom_range(0, 255));
        flow  = SAMPLE_W'($urandom_range(0, 255));
        repeat (256) send_pair(level, flow);
    endtask

    // Lowering the window below the running count: the count has to wrap.
    task automatic test_window_lowered_midway();
        set_window(8'd100);
        refill_pools();
        repeat (40) send_random_pair();
        set_window(8'd20);
        refill_pools();
        do begin
            send_random_pair();
        end while (fill_count != 0);
        // The count has wrapped; the window now closes at the new length.
        do begin
            send_random_pair();
        end while (fill_count != 0);
    endtask

    // The receiver holds off for a long stretch while samples keep coming.
    task automatic test_output_stall();
        set_window(8'd1);
        refill_pools();
        send_idle_pct = 0;
        hold_left     = 300;
        repeat (40) send_random_pair();
    endtask

    // Random window lengths, each run for a few whole windows.
    task automatic test_random_windows(input int n_items, input int s_pct, input int r_pct);
        int sent;
        int roll;
        int win;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                win = $urandom_range(1, 12);
            end else if (roll < 95) begin
                win = $urandom_range(13, 48);
            end else begin
                win = $urandom_range(200, 255);
            end
            set_window(WIN_W'(win));
            refill_pools();
            repeat ($urandom_range(1, 3)) begin
                do begin
                    send_random_pair();
                    sent++;
                end while (fill_count != 0);
            end
        end
    endtask

    // Receiver: random backpressure, or a counted hold-off when one is asked.
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Compare each result transfer with the oldest expected pair of modes.
    always @(posedge aclk) begin
        mode_pair_t exp_m;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_modes.size() == 0) begin
                $error("unexpected result: level_mode %0h flow_mode %0h",
                       m_tdata[7:0], m_tdata[15:8]);
                errors++;
            end else begin
                exp_m = expected_modes.pop_front();
                if (m_tdata[7:0] !== exp_m.level_mode) begin
                    $error("level_mode: expected %0h, got %0h", exp_m.level_mode, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[15:8] !== exp_m.flow_mode) begin
                    $error("flow_mode: expected %0h, got %0h", exp_m.flow_mode, m_tdata[15:8]);
                    errors++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_windowed_mode_filter_pair_core: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        errors        = 0;
        idle_cycles   = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        window_len    = wmf_pkg::WINDOW_RESET;
        clear_histograms();
        refill_pools();

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_window();
        test_window_one();
        test_window_max();
        test_window_zero_saturation();
        test_window_lowered_midway();
        test_output_stall();
        test_random_windows(330, 27, 85);
        test_random_windows(330, 85, 27);
        test_random_windows(330, 0, 0);

        drain_results();
        repeat (8) @(posedge aclk);
        if (expected_modes.size() != 0) begin
            $error("%0d expected results never arrived", expected_modes.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb_windowed_mode_filter_pair_core: done, clean");
        end else begin
            $display("tb_windowed_mode_filter_pair_core: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hdl/wmf_pkg.sv
hdl/wmf_hist_chan.sv
hdl/windowed_mode_filter_pair_core.sv
tb/sv/tb_windowed_mode_filter_pair_core.sv
